/* rtl/bfmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bfmd_pkg;

  localparam int CFG_W       = 9;
  localparam int CC_W        = 3;
  localparam int REG_INDEX_W = 2;
  localparam int CHANNELS    = 4;
  localparam int BYTE_W      = 8;
  localparam int SUM_W       = 11;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_DEPTH  = 256;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1);
  localparam logic [CC_W-1:0]  CC_RESET   = CC_W'(4);
  localparam logic [CC_W-1:0]  CC_MAX     = CC_W'(CHANNELS);

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SOURCE_DEPTH  = 2'd2,
    REG_CHANNEL_COUNT = 2'd3
  } cfg_reg_e;

  typedef logic [CHANNELS-1:0][BYTE_W-1:0] chan_bytes_t;
  typedef logic [CHANNELS-1:0][SUM_W-1:0]  chan_sums_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_in;
    logic [BYTE_W-1:0] green_in;
    logic [BYTE_W-1:0] blue_in;
    logic [BYTE_W-1:0] alpha_in;
  } in_texel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_out;
    logic [BYTE_W-1:0] green_out;
    logic [BYTE_W-1:0] blue_out;
    logic [BYTE_W-1:0] alpha_out;
    logic              level_done;
  } out_texel_t;

endpackage

`default_nettype wire

/* rtl/bfmd_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bfmd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/bfmd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bfmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write to the same entry returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/box_filter_mip_downsample.sv */
// A destination texel goes to the output queue from the s1 register that holds the
// last source texel of its block, then out on dest_texel; other source texels give no item.
// Throughput: one source texel per cycle while the output queue has room, set by the
// accumulator RAM's read-modify-write, which forwards the previous write to avoid a stall.
// Reset: registers go to 1x1x1 with four channels, positions to zero; the
// accumulator RAM is not cleared, as the first texel of each block writes its entry.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_mip_downsample #(
  parameter int MAX_WIDTH  = bfmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bfmd_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_DEPTH  = bfmd_pkg::DEF_MAX_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  bfmd_stream_if.sink                             source_texel,
  bfmd_stream_if.source                           dest_texel,
  input  wire logic                               write_enable,
  input  wire logic [bfmd_pkg::REG_INDEX_W-1:0]   reg_index,
  input  wire logic [bfmd_pkg::CFG_W-1:0]         write_data
);

  import bfmd_pkg::*;

  localparam int PXW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int PYW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PZW   = (MAX_DEPTH  > 1) ? $clog2(MAX_DEPTH)  : 1;
  localparam int PLANE = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int AW    = (PLANE > 1) ? $clog2(PLANE) : 1;
  localparam int RAM_W = CHANNELS * SUM_W;

  typedef struct packed {
    logic              keep;
    logic              first;
    logic              last;
    logic              done;
    logic [AW-1:0]     addr;
    chan_bytes_t       bytes;
  } acc_op_t;

  // configuration registers
  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic [CFG_W-1:0] source_depth;
  logic [CC_W-1:0]  channel_count;

  // source position
  logic [PXW-1:0] column_position;
  logic [PYW-1:0] row_position;
  logic [PZW-1:0] slice_position;
  logic [AW:0]    row_base;

  // derived sizes
  logic [CFG_W-1:0] w_eff, h_eff, d_eff;
  logic [CFG_W-1:0] dw, dh, dd;
  logic [CC_W-1:0]  cc_eff;
  logic [1:0]       shift;

  // accumulate stage
  logic             s1_valid;
  acc_op_t          s1;
  acc_op_t          s0;
  logic             wb_valid;
  logic [AW-1:0]    wb_addr;
  chan_sums_t       wb_data;
  logic [RAM_W-1:0] ram_rdata;
  chan_sums_t       old_sums;
  chan_sums_t       new_sums;
  logic             ram_we;
  logic             push;
  out_texel_t       result;

  // output queue
  out_texel_t       out_q [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       occ;
  logic             pop;
  logic [2:0]       pending;

  logic             accept;
  logic             wrap_x, wrap_y, wrap_z;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int max_v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > max_v) begin
      r = CFG_W'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] half_size(input logic [CFG_W-1:0] v);
    return (v > CFG_W'(1)) ? (v >> 1) : CFG_W'(1);
  endfunction

  always_comb begin
    w_eff = clamp_size(source_width,  MAX_WIDTH);
    h_eff = clamp_size(source_height, MAX_HEIGHT);
    d_eff = clamp_size(source_depth,  MAX_DEPTH);
    dw    = half_size(w_eff);
    dh    = half_size(h_eff);
    dd    = half_size(d_eff);
    shift = 2'(w_eff > CFG_W'(1)) + 2'(h_eff > CFG_W'(1)) + 2'(d_eff > CFG_W'(1));
    if (channel_count == '0) begin
      cc_eff = CC_W'(1);
    end else if (channel_count > CC_MAX) begin
      cc_eff = CC_MAX;
    end else begin
      cc_eff = channel_count;
    end
  end

  // decode the incoming texel against the current position
  always_comb begin
    s0.keep  = (w_eff == CFG_W'(1) || 32'(column_position) < (32'(dw) << 1)) &&
               (h_eff == CFG_W'(1) || 32'(row_position)    < (32'(dh) << 1)) &&
               (d_eff == CFG_W'(1) || 32'(slice_position)  < (32'(dd) << 1));
    s0.first = !(column_position[0] || row_position[0] || slice_position[0]);
    s0.last  = (w_eff == CFG_W'(1) || column_position[0]) &&
               (h_eff == CFG_W'(1) || row_position[0]) &&
               (d_eff == CFG_W'(1) || slice_position[0]);
    s0.done  = (32'(column_position >> 1) == 32'(dw) - 32'd1) &&
               (32'(row_position    >> 1) == 32'(dh) - 32'd1) &&
               (32'(slice_position  >> 1) == 32'(dd) - 32'd1);
    s0.addr  = AW'(row_base + (AW+1)'(column_position >> 1));
    s0.bytes[0] = source_texel.data.red_in;
    s0.bytes[1] = source_texel.data.green_in;
    s0.bytes[2] = source_texel.data.blue_in;
    s0.bytes[3] = source_texel.data.alpha_in;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c >= int'(cc_eff)) begin
        s0.bytes[c] = '0;
      end
    end
  end

  bfmd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (PLANE)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1.addr),
    .wdata (new_sums),
    .raddr (s0.addr),
    .rdata (ram_rdata)
  );

  // forward the write that landed while this entry was being read
  always_comb begin
    old_sums = (wb_valid && wb_addr == s1.addr) ? wb_data : chan_sums_t'(ram_rdata);
    for (int c = 0; c < CHANNELS; c++) begin
      new_sums[c] = s1.first ? SUM_W'(s1.bytes[c]) : old_sums[c] + SUM_W'(s1.bytes[c]);
    end
    ram_we = s1_valid && s1.keep;
    push   = ram_we && s1.last;
    result.red_out    = BYTE_W'(new_sums[0] >> shift);
    result.green_out  = (cc_eff > CC_W'(1)) ? BYTE_W'(new_sums[1] >> shift) : '0;
    result.blue_out   = (cc_eff > CC_W'(2)) ? BYTE_W'(new_sums[2] >> shift) : '0;
    result.alpha_out  = (cc_eff > CC_W'(3)) ? BYTE_W'(new_sums[3] >> shift) : '0;
    result.level_done = s1.done;
  end

  // take a texel only if its possible result still finds room in the queue
  always_comb begin
    pop     = (occ != 2'd0) && dest_texel.ready;
    pending = 3'(occ) + 3'(push) - 3'(pop);
    source_texel.ready = (pending <= 3'd1);
    accept  = source_texel.valid && source_texel.ready;
    dest_texel.valid = (occ != 2'd0);
    dest_texel.data  = out_q[rd_ptr];
    wrap_x  = (32'(column_position) + 32'd1 >= 32'(w_eff));
    wrap_y  = (32'(row_position)    + 32'd1 >= 32'(h_eff));
    wrap_z  = (32'(slice_position)  + 32'd1 >= 32'(d_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width    <= SIZE_RESET;
      source_height   <= SIZE_RESET;
      source_depth    <= SIZE_RESET;
      channel_count   <= CC_RESET;
      column_position <= '0;
      row_position    <= '0;
      slice_position  <= '0;
      row_base        <= '0;
    end else if (write_enable) begin
      case (cfg_reg_e'(reg_index))
        REG_SOURCE_WIDTH:  source_width  <= write_data;
        REG_SOURCE_HEIGHT: source_height <= write_data;
        REG_SOURCE_DEPTH:  source_depth  <= write_data;
        REG_CHANNEL_COUNT: channel_count <= CC_W'(write_data);
        default: ;
      endcase
      column_position <= '0;
      row_position    <= '0;
      slice_position  <= '0;
      row_base        <= '0;
    end else if (accept) begin
      if (wrap_x) begin
        column_position <= '0;
        if (wrap_y) begin
          row_position <= '0;
          row_base     <= '0;
          slice_position <= wrap_z ? '0 : slice_position + PZW'(1);
        end else begin
          row_position <= row_position + PYW'(1);
          // advance one destination row after each odd source row
          if (row_position[0]) begin
            row_base <= row_base + (AW+1)'(dw);
          end
        end
      end else begin
        column_position <= column_position + PXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wb_valid <= 1'b0;
      occ      <= '0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
    end else begin
      s1_valid <= accept;
      wb_valid <= ram_we;
      occ      <= 2'(pending);
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s0;
    end
    wb_addr <= s1.addr;
    wb_data <= new_sums;
    if (push) begin
      out_q[wr_ptr] <= result;
    end
  end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import bfmd_pkg::*;

  localparam int PLANE_ENTRIES = (DEF_MAX_WIDTH / 2) * (DEF_MAX_HEIGHT / 2);
  localparam int MAX_PRINTS    = 100;
  localparam int RANDOM_TEXELS = 600;
  localparam int DRAIN_CYCLES  = 6;

  typedef enum {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_PERIODIC} stall_mode_e;
  typedef enum {PH_LEVELS, PH_BROKEN, PH_WIDE, PH_TALL, PH_DEEP} phase_kind_e;

  // Box-filter predictor plus the queue of destination texels still owed by the block.
  class texel_scoreboard;
    chan_sums_t       plane [PLANE_ENTRIES];
    logic [CFG_W-1:0] width_q, height_q, depth_q;
    logic [CC_W-1:0]  chan_q;
    int unsigned      col_pos, row_pos, slice_pos;
    out_texel_t       owed_q [$];
    int               errors;

    function new();
      width_q   = SIZE_RESET;
      height_q  = SIZE_RESET;
      depth_q   = SIZE_RESET;
      chan_q    = CC_RESET;
      col_pos   = 0;
      row_pos   = 0;
      slice_pos = 0;
      errors    = 0;
    endfunction

    static function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    function void set_reg(cfg_reg_e which, logic [CFG_W-1:0] val);
      case (which)
        REG_SOURCE_WIDTH:  width_q  = val;
        REG_SOURCE_HEIGHT: height_q = val;
        REG_SOURCE_DEPTH:  depth_q  = val;
        REG_CHANNEL_COUNT: chan_q   = val[CC_W-1:0];
      endcase
      // any write restarts the level
      col_pos   = 0;
      row_pos   = 0;
      slice_pos = 0;
    endfunction

    // Returns 1 when the texel falls inside a 2x2x2 block, 0 when it is dropped.
    function bit note_texel(in_texel_t t);
      int unsigned       w, h, d, cc, dw, dh, dd, span, idx;
      logic [BYTE_W-1:0] bytes [CHANNELS];
      logic [BYTE_W-1:0] avg [CHANNELS];
      logic [SUM_W-1:0]  v;
      bit                used, first, last, done;
      w  = clamp_dim(width_q, DEF_MAX_WIDTH);
      h  = clamp_dim(height_q, DEF_MAX_HEIGHT);
      d  = clamp_dim(depth_q, DEF_MAX_DEPTH);
      cc = (chan_q == 0) ? 1 : ((chan_q > CC_MAX) ? CHANNELS : chan_q);
      dw = (w > 1) ? w / 2 : 1;
      dh = (h > 1) ? h / 2 : 1;
      dd = (d > 1) ? d / 2 : 1;
      span = ((w > 1) ? 1 : 0) + ((h > 1) ? 1 : 0) + ((d > 1) ? 1 : 0);
      bytes = '{t.red_in, t.green_in, t.blue_in, t.alpha_in};
      used = (w == 1 || col_pos < 2 * dw) && (h == 1 || row_pos < 2 * dh) &&
             (d == 1 || slice_pos < 2 * dd);
      if (used) begin
        idx   = (row_pos >> 1) * dw + (col_pos >> 1);
        first = ((col_pos | row_pos | slice_pos) & 1) == 0;
        last  = (w == 1 || col_pos[0]) && (h == 1 || row_pos[0]) &&
                (d == 1 || slice_pos[0]);
        for (int c = 0; c < CHANNELS; c++) begin
          v = (c < cc) ? SUM_W'(bytes[c]) : '0;
          plane[idx][c] = first ? v : plane[idx][c] + v;
        end
        if (last) begin
          for (int c = 0; c < CHANNELS; c++)
            avg[c] = (c < cc) ? BYTE_W'(plane[idx][c] >> span) : '0;
          done = (col_pos >> 1) == dw - 1 && (row_pos >> 1) == dh - 1 &&
                 (slice_pos >> 1) == dd - 1;
          owed_q.push_back('{avg[0], avg[1], avg[2], avg[3], done});
        end
      end
      // advance in raster order, wrapping into the next level
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          slice_pos++;
          if (slice_pos >= d) slice_pos = 0;
        end
      end
      return used;
    endfunction

    task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
    endtask

    task check_texel(out_texel_t got);
      out_texel_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected destination texel 0x%010h", got));
      end else begin
        want = owed_q.pop_front();
        compare_field("red_out", got.red_out, want.red_out);
        compare_field("green_out", got.green_out, want.green_out);
        compare_field("blue_out", got.blue_out, want.blue_out);
        compare_field("alpha_out", got.alpha_out, want.alpha_out);
        compare_field("level_done", BYTE_W'(got.level_done), BYTE_W'(want.level_done));
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction

    task check_drained();
      if (owed_q.size() != 0)
        report_mismatch($sformatf("%0d destination texels never arrived", owed_q.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [CFG_W-1:0] write_data;

  bfmd_stream_if #(.T(in_texel_t))  src_if ();
  bfmd_stream_if #(.T(out_texel_t)) dst_if ();

  texel_scoreboard sb = new();

  int          burst_left = 0;
  int          sent_count = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_left = 0;
  int unsigned stall_tick = 0;

  box_filter_mip_downsample i_dut (
    .clk          (clk),
    .rst          (rst),
    .source_texel (src_if),
    .dest_texel   (dst_if),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always #5 clk = ~clk;

  // Receiver: check each accepted texel, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst && dst_if.valid && dst_if.ready) sb.check_texel(dst_if.data);
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 80);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE:     dst_if.ready <= 1'b1;
      STALL_HALF:     dst_if.ready <= 1'($urandom_range(0, 1));
      STALL_SPARSE:   dst_if.ready <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: dst_if.ready <= (stall_tick % 3) != 0;
    endcase
  end

  task automatic send_texel(input in_texel_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        src_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    src_if.valid <= 1'b1;
    src_if.data  <= t;
    do @(posedge clk); while (!src_if.ready);
    void'(sb.note_texel(t));
    sent_count++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_texel(in_texel_t'($urandom));
  endtask

  // Hold the sender until every owed texel is out and the pipeline is empty.
  task automatic wait_idle();
    src_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_W-1:0] val);
    write_enable <= 1'b1;
    reg_index    <= which;
    write_data   <= val;
    sb.set_reg(which, val);
    @(posedge clk);
  endtask

  task automatic load_level(input logic [CFG_W-1:0] w, h, d, input logic [CC_W-1:0] cc);
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_SOURCE_DEPTH, d);
    // upper data bits are outside the register and must be ignored
    write_reg(REG_CHANNEL_COUNT, {(CFG_W - CC_W)'($urandom), cc});
    write_enable <= 1'b0;
  endtask

  function automatic int unsigned level_texels(logic [CFG_W-1:0] w, h, d);
    return texel_scoreboard::clamp_dim(w, DEF_MAX_WIDTH) *
           texel_scoreboard::clamp_dim(h, DEF_MAX_HEIGHT) *
           texel_scoreboard::clamp_dim(d, DEF_MAX_DEPTH);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim(int unsigned hi);
    return ($urandom_range(0, 7) == 0) ? '0 : CFG_W'($urandom_range(1, hi));
  endfunction

  function automatic logic [CFG_W-1:0] big_dim();
    case ($urandom_range(0, 4))
      0: return CFG_W'(256);
      1: return CFG_W'(255);
      2: return CFG_W'(257);
      3: return CFG_W'(511);
      default: return CFG_W'($urandom_range(64, 256));
    endcase
  endfunction

  initial begin
    phase_kind_e      kind;
    int               roll, n;
    logic [CFG_W-1:0] w, h, d;
    logic [CC_W-1:0]  cc;

    rst          <= 1'b1;
    src_if.valid <= 1'b0;
    src_if.data  <= '0;
    write_enable <= 1'b0;
    reg_index    <= REG_SOURCE_WIDTH;
    write_data   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: 1x1x1, every texel passes straight through
    send_texel(in_texel_t'(32'h0000_0000));
    send_texel(in_texel_t'(32'hFFFF_FFFF));
    send_texel(in_texel_t'(32'hAA55_AA55));
    send_texel(in_texel_t'(32'h55AA_0FF0));

    // full 2x2x2 block of maximum bytes
    wait_idle();
    load_level(9'd2, 9'd2, 9'd2, 3'd4);
    repeat (8) send_texel(in_texel_t'(32'hFFFF_FFFF));

    // odd width drops its last column; zero channel count acts as one
    wait_idle();
    load_level(9'd3, 9'd1, 9'd1, 3'd0);
    send_random(3);

    // zero sizes act as one, odd height drops its last row, count above four
    wait_idle();
    load_level(9'd0, 9'd3, 9'd0, 3'd7);
    send_random(3);

    // a register write in the middle of a level restarts it
    wait_idle();
    load_level(9'd2, 9'd2, 9'd1, 3'd2);
    send_random(2);
    wait_idle();
    load_level(9'd2, 9'd2, 9'd1, 3'd2);
    send_random(4);

    sent_count = 0;
    while (sent_count < RANDOM_TEXELS) begin
      roll = $urandom_range(0, 9);
      kind = (roll < 6) ? PH_LEVELS : (roll == 6) ? PH_BROKEN :
             (roll == 7) ? PH_WIDE : (roll == 8) ? PH_TALL : PH_DEEP;
      cc = CC_W'($urandom_range(0, 7));
      case (kind)
        PH_WIDE: begin
          w = big_dim();
          h = CFG_W'($urandom_range(1, 3));
          d = CFG_W'($urandom_range(1, 2));
        end
        PH_TALL: begin
          w = CFG_W'($urandom_range(1, 2));
          h = big_dim();
          d = CFG_W'($urandom_range(1, 2));
        end
        PH_DEEP: begin
          w = CFG_W'($urandom_range(1, 2));
          h = CFG_W'($urandom_range(1, 2));
          d = big_dim();
        end
        default: begin
          w = pick_dim(7);
          h = pick_dim(6);
          d = pick_dim(4);
        end
      endcase
      case (kind)
        PH_LEVELS: n = $urandom_range(1, 3) * level_texels(w, h, d);
        PH_BROKEN: n = $urandom_range(1, level_texels(w, h, d));
        default:   n = $urandom_range(16, 96);
      endcase
      wait_idle();
      load_level(w, h, d, cc);
      send_random(n);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
